// ===== hw/rtl/hpad_pkg.sv =====
// Shared types, constants and tables of the high-pass arctangent distortion unit.
`timescale 1ns / 1ps
package hpad_pkg;

    localparam int NUM_CHANNELS_DEF    = 2;
    localparam int ATAN_TABLE_BITS_DEF = 10;

    localparam int SAMPLE_W   = 16;
    localparam int FILT_W     = 24;
    localparam int COEF_W     = 16;
    localparam int DRIVE_W    = 20;
    localparam int BLEND_W    = 17;
    localparam int VOL_W      = 16;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int MUL_A_W   = 26;
    localparam int MUL_B_W   = 20;
    localparam int PROD_W    = MUL_A_W + MUL_B_W + 1;
    localparam int ACC_W     = 62;
    localparam int CORDIC_W  = 44;
    localparam int ANGLE_W   = 26;
    localparam int LUT_W     = 24;
    localparam int LUT_IDX_W = 4;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_HP_FORWARD  = 3'd0;
    localparam cfg_idx_t CFG_HP_FEEDBACK = 3'd1;
    localparam cfg_idx_t CFG_DRIVE       = 3'd2;
    localparam cfg_idx_t CFG_BLEND       = 3'd3;
    localparam cfg_idx_t CFG_VOLUME      = 3'd4;

    localparam logic [COEF_W-1:0]  HP_FORWARD_RST  = 16'd61171;
    localparam logic [COEF_W-1:0]  HP_FEEDBACK_RST = 16'd56805;
    localparam logic [DRIVE_W-1:0] DRIVE_RST       = 20'd154;
    localparam logic [BLEND_W-1:0] BLEND_RST       = 17'd39322;
    localparam logic [VOL_W-1:0]   VOLUME_RST      = 16'd16384;
    localparam logic [BLEND_W-1:0] BLEND_ONE       = 17'd65536;

    typedef logic [2:0] mul_sel_t;
    localparam mul_sel_t MUL_NONE      = 3'd0;
    localparam mul_sel_t MUL_DIFF_B0   = 3'd1;
    localparam mul_sel_t MUL_LF_C      = 3'd2;
    localparam mul_sel_t MUL_F_DRIVE   = 3'd3;
    localparam mul_sel_t MUL_DRV_BLEND = 3'd4;
    localparam mul_sel_t MUL_F_CLEAN   = 3'd5;
    localparam mul_sel_t MUL_LO_VOL    = 3'd6;
    localparam mul_sel_t MUL_HI_VOL    = 3'd7;

    typedef logic [2:0] acc_op_t;
    localparam acc_op_t ACC_HOLD     = 3'd0;
    localparam acc_op_t ACC_LOAD     = 3'd1;
    localparam acc_op_t ACC_LOAD_SH6 = 3'd2;
    localparam acc_op_t ACC_ADD      = 3'd3;
    localparam acc_op_t ACC_ADD_SH3  = 3'd4;
    localparam acc_op_t ACC_ADD_SH24 = 3'd5;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     filt_wr;
        logic     cordic_init;
        logic     cordic_step;
        logic     drv_wr;
        logic     out_load;
    } hpad_cmd_t;

    typedef struct packed {
        logic cordic_last;
        logic out_free;
    } hpad_status_t;

    // (2/pi)*atan(2^-i) in units of 2^-24
    function automatic logic [LUT_W-1:0] angle_lut(input logic [LUT_IDX_W-1:0] i);
        logic [LUT_W-1:0] v;
        case (i)
            4'd0:    v = 24'd8388608;
            4'd1:    v = 24'd4952084;
            4'd2:    v = 24'd2616545;
            4'd3:    v = 24'd1328199;
            4'd4:    v = 24'd666677;
            4'd5:    v = 24'd333663;
            4'd6:    v = 24'd166872;
            4'd7:    v = 24'd83441;
            4'd8:    v = 24'd41721;
            4'd9:    v = 24'd20861;
            4'd10:   v = 24'd10430;
            4'd11:   v = 24'd5215;
            4'd12:   v = 24'd2608;
            4'd13:   v = 24'd1304;
            4'd14:   v = 24'd652;
            4'd15:   v = 24'd326;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/hpad_ifs.sv =====
// Word channel interfaces: input samples, output samples and configuration writes.
`timescale 1ns / 1ps
interface hpad_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 channel_id;
    logic signed [hpad_pkg::SAMPLE_W-1:0] sample_in;

    modport source (output valid, output channel_id, output sample_in, input ready);
    modport sink   (input valid, input channel_id, input sample_in, output ready);
endinterface

interface hpad_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 channel_out;
    logic signed [hpad_pkg::SAMPLE_W-1:0] sample_out;

    modport source (output valid, output channel_out, output sample_out, input ready);
    modport sink   (input valid, input channel_out, input sample_out, output ready);
endinterface

interface hpad_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [hpad_pkg::CFG_IDX_W-1:0]   index;
    logic [hpad_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/highpass_atan_distortion_unit.sv =====
// Top level of the high-pass arctangent distortion unit.
//
// in_ch takes one word per sample: channel_id and signed Q1.15 sample_in. Each
// channel runs a first-order high-pass, the result is split into a clean path and
// an arctangent soft-clip path, blended, scaled by the volume and saturated.
// out_ch returns one word per input word, in order: channel_out and sample_out.
// cfg writes one of five registers per word (index 0..4); it is always ready and
// should only be used while no sample is in flight.
// A new word is accepted only once the previous one has been through the whole sequence,
// set by the single shared multiplier and the one-step-per-cycle CORDIC loop.
// Reset clears channel history, loads register defaults and empties the output.
// A finished word waits in the output register; the next input word is accepted
// meanwhile and its result is held back until the receiver takes the first.
`timescale 1ns / 1ps
module highpass_atan_distortion_unit #(
    parameter int NUM_CHANNELS    = hpad_pkg::NUM_CHANNELS_DEF,
    parameter int ATAN_TABLE_BITS = hpad_pkg::ATAN_TABLE_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    hpad_in_if.sink         in_ch,
    hpad_out_if.source      out_ch,
    hpad_cfg_if.sink        cfg
);
    import hpad_pkg::*;

    hpad_cmd_t    cmd;
    hpad_status_t status;

    hpad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    hpad_datapath #(
        .NUM_CHANNELS    (NUM_CHANNELS),
        .ATAN_TABLE_BITS (ATAN_TABLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .channel_id  (in_ch.channel_id),
        .sample_in   (in_ch.sample_in),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .channel_out (out_ch.channel_out),
        .sample_out  (out_ch.sample_out),
        .cfg_valid   (cfg.valid),
        .cfg_ready   (cfg.ready),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data)
    );

endmodule

// ===== hw/rtl/hpad_cordic.sv =====
// Iterative CORDIC vectoring unit, one micro-rotation per cycle while step is high, normalized angle out.
`timescale 1ns / 1ps
module hpad_cordic #(
    parameter int ATAN_TABLE_BITS = hpad_pkg::ATAN_TABLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  init,
    input  logic                                  step,
    input  logic signed [hpad_pkg::CORDIC_W-1:0]  y_init,
    output logic signed [hpad_pkg::ANGLE_W-1:0]   z,
    output logic                                  last
);
    import hpad_pkg::*;

    localparam int IT_W = $clog2(ATAN_TABLE_BITS);
    localparam logic [IT_W-1:0] LAST_IT = IT_W'(ATAN_TABLE_BITS - 1);
    localparam logic signed [CORDIC_W-1:0] X_ONE = CORDIC_W'(64'sd536870912);

    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic signed [ANGLE_W-1:0]  z_reg, z_next;
    logic [IT_W-1:0]            cnt_reg, cnt_next;
    logic signed [CORDIC_W-1:0] dx, dy;
    logic signed [ANGLE_W-1:0]  ang;

    assign dx   = y_reg >>> cnt_reg;
    assign dy   = x_reg >>> cnt_reg;
    assign ang  = $signed({2'b00, angle_lut(LUT_IDX_W'(cnt_reg))});
    assign last = (cnt_reg == LAST_IT);
    assign z    = z_reg;

    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        z_next   = z_reg;
        cnt_next = cnt_reg;
        if (init)
        begin
            x_next   = X_ONE;
            y_next   = y_init;
            z_next   = '0;
            cnt_next = '0;
        end
        else if (step)
        begin
            if (!y_reg[CORDIC_W-1])
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + ang;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - ang;
            end
            if (!last)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

endmodule

// ===== hw/rtl/hpad_datapath.sv =====
// Datapath: config registers, channel state, shared multiplier, accumulator, output register.
`timescale 1ns / 1ps
module hpad_datapath #(
    parameter int NUM_CHANNELS    = hpad_pkg::NUM_CHANNELS_DEF,
    parameter int ATAN_TABLE_BITS = hpad_pkg::ATAN_TABLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  hpad_pkg::hpad_cmd_t                  cmd,
    output hpad_pkg::hpad_status_t               status,
    input  logic                                 channel_id,
    input  logic signed [hpad_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 channel_out,
    output logic signed [hpad_pkg::SAMPLE_W-1:0] sample_out,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hpad_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hpad_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import hpad_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic signed [ACC_W-1:0] FILT_HALF = ACC_W'(64'sd32768);
    localparam logic signed [ACC_W-1:0] FILT_MAX  = ACC_W'(64'sd8388607);
    localparam logic signed [ACC_W-1:0] FILT_MIN  = -ACC_W'(64'sd8388608);
    localparam logic signed [ACC_W-1:0] ARG_LIM   = ACC_W'(64'sd2199023255552);
    localparam logic signed [ACC_W-1:0] OUT_HALF  = ACC_W'(64'sd549755813888);
    localparam logic signed [ACC_W-1:0] OUT_MAX   = ACC_W'(64'sd32767);
    localparam logic signed [ACC_W-1:0] OUT_MIN   = -ACC_W'(64'sd32768);

    logic [COEF_W-1:0]  b0_reg, c_reg;
    logic [DRIVE_W-1:0] drive_reg;
    logic [BLEND_W-1:0] blend_reg;
    logic [VOL_W-1:0]   vol_reg;

    logic signed [SAMPLE_W-1:0] li_reg [NUM_CHANNELS];
    logic signed [FILT_W-1:0]   lf_reg [NUM_CHANNELS];

    logic                       ch_reg;
    logic [CH_W-1:0]            idx_reg, idx_in;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [FILT_W-1:0]   f_reg, f_sat;
    logic                       neg_reg, zero_reg;
    logic signed [ANGLE_W-1:0]  driven_reg, cordic_z;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next, prod_ext;
    logic signed [ACC_W-1:0]    filt_full, out_full, mag_full;
    logic                       out_valid_reg, out_ch_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg, res_sat;

    logic signed [MUL_A_W-1:0]  a_op;
    logic [MUL_B_W-1:0]         b_op;
    logic signed [MUL_B_W:0]    b_ext;
    logic [BLEND_W-1:0]         blend_c, clean_w;
    logic                       cordic_last;

    assign cfg_ready = 1'b1;
    assign idx_in    = (NUM_CHANNELS > 1) ? CH_W'(channel_id) : '0;
    assign blend_c   = (blend_reg > BLEND_ONE) ? BLEND_ONE : blend_reg;
    assign clean_w   = BLEND_ONE - blend_c;

    // shared multiplier, operands picked by the sequencer
    always_comb
    begin
        a_op = '0;
        b_op = '0;
        case (cmd.mul_sel)
            MUL_DIFF_B0:
            begin
                a_op = MUL_A_W'(diff_reg);
                b_op = MUL_B_W'(b0_reg);
            end
            MUL_LF_C:
            begin
                a_op = MUL_A_W'(lf_reg[idx_reg]);
                b_op = MUL_B_W'(c_reg);
            end
            MUL_F_DRIVE:
            begin
                a_op = MUL_A_W'(f_reg);
                b_op = drive_reg;
            end
            MUL_DRV_BLEND:
            begin
                a_op = driven_reg;
                b_op = MUL_B_W'(blend_c);
            end
            MUL_F_CLEAN:
            begin
                a_op = MUL_A_W'(f_reg);
                b_op = MUL_B_W'(clean_w);
            end
            MUL_LO_VOL:
            begin
                a_op = MUL_A_W'({1'b0, acc_reg[23:0]});
                b_op = MUL_B_W'(vol_reg);
            end
            MUL_HI_VOL:
            begin
                a_op = MUL_A_W'($signed(acc_reg[43:24]));
                b_op = MUL_B_W'(vol_reg);
            end
            default:
            begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    assign b_ext    = $signed({1'b0, b_op});
    assign prod_ext = ACC_W'(prod_reg);

    always_comb
    begin
        case (cmd.acc_op)
            ACC_HOLD:     acc_next = acc_reg;
            ACC_LOAD:     acc_next = prod_ext;
            ACC_LOAD_SH6: acc_next = prod_ext <<< 6;
            ACC_ADD:      acc_next = acc_reg + prod_ext;
            ACC_ADD_SH3:  acc_next = acc_reg + (prod_ext <<< 3);
            ACC_ADD_SH24: acc_next = acc_reg + (prod_ext <<< 24);
            default:      acc_next = acc_reg;
        endcase
    end

    // filter rounding and saturation
    always_comb
    begin
        filt_full = (acc_reg + FILT_HALF) >>> 16;
        if (filt_full > FILT_MAX)
        begin
            f_sat = FILT_W'(FILT_MAX);
        end
        else if (filt_full < FILT_MIN)
        begin
            f_sat = FILT_W'(FILT_MIN);
        end
        else
        begin
            f_sat = FILT_W'(filt_full);
        end
    end

    // arctangent argument magnitude, clamped
    always_comb
    begin
        if (acc_reg > ARG_LIM || acc_reg < -ARG_LIM)
        begin
            mag_full = ARG_LIM;
        end
        else if (acc_reg < 0)
        begin
            mag_full = -acc_reg;
        end
        else
        begin
            mag_full = acc_reg;
        end
    end

    // final rounding and saturation
    always_comb
    begin
        out_full = (acc_reg + OUT_HALF) >>> 40;
        if (out_full > OUT_MAX)
        begin
            res_sat = SAMPLE_W'(OUT_MAX);
        end
        else if (out_full < OUT_MIN)
        begin
            res_sat = SAMPLE_W'(OUT_MIN);
        end
        else
        begin
            res_sat = SAMPLE_W'(out_full);
        end
    end

    hpad_cordic #(
        .ATAN_TABLE_BITS (ATAN_TABLE_BITS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .init   (cmd.cordic_init),
        .step   (cmd.cordic_step),
        .y_init (CORDIC_W'(mag_full)),
        .z      (cordic_z),
        .last   (cordic_last)
    );

    assign status.cordic_last = cordic_last;
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign channel_out = out_ch_reg;
    assign sample_out  = out_sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg        <= HP_FORWARD_RST;
            c_reg         <= HP_FEEDBACK_RST;
            drive_reg     <= DRIVE_RST;
            blend_reg     <= BLEND_RST;
            vol_reg       <= VOLUME_RST;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                li_reg[i] <= '0;
                lf_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_HP_FORWARD:  b0_reg    <= cfg_data[COEF_W-1:0];
                    CFG_HP_FEEDBACK: c_reg     <= cfg_data[COEF_W-1:0];
                    CFG_DRIVE:       drive_reg <= cfg_data[DRIVE_W-1:0];
                    CFG_BLEND:       blend_reg <= cfg_data[BLEND_W-1:0];
                    CFG_VOLUME:      vol_reg   <= cfg_data[VOL_W-1:0];
                    default:         ;
                endcase
            end
            if (cmd.filt_wr)
            begin
                li_reg[idx_reg] <= x_reg;
                lf_reg[idx_reg] <= f_sat;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_op * b_ext;
        acc_reg  <= acc_next;
        if (cmd.load)
        begin
            ch_reg   <= channel_id;
            idx_reg  <= idx_in;
            x_reg    <= sample_in;
            diff_reg <= DIFF_W'(sample_in) - DIFF_W'(li_reg[idx_in]);
        end
        if (cmd.filt_wr)
        begin
            f_reg <= f_sat;
        end
        if (cmd.cordic_init)
        begin
            neg_reg  <= acc_reg < 0;
            zero_reg <= acc_reg == 0;
        end
        if (cmd.drv_wr)
        begin
            if (zero_reg)
            begin
                driven_reg <= '0;
            end
            else if (neg_reg)
            begin
                driven_reg <= -cordic_z;
            end
            else
            begin
                driven_reg <= cordic_z;
            end
        end
        if (cmd.out_load)
        begin
            out_ch_reg     <= ch_reg;
            out_sample_reg <= res_sat;
        end
    end

`ifndef SYNTHESIS
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken word");

    a_state_written: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.filt_wr |=> (lf_reg[idx_reg] == f_reg && li_reg[idx_reg] == x_reg))
        else $error("channel state not updated with filtered value");

    a_zero_driven: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.drv_wr && zero_reg) |=> (driven_reg == '0))
        else $error("zero argument gave nonzero driven path");
`endif

endmodule

// ===== hw/rtl/hpad_ctrl.sv =====
// Sequencer that steps the datapath through filter, arctangent, mix and volume scaling for each word.
`timescale 1ns / 1ps
module hpad_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  hpad_pkg::hpad_status_t status,
    output hpad_pkg::hpad_cmd_t    cmd
);
    import hpad_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_MB0   = 5'd1;
    localparam logic [4:0] S_MC    = 5'd2;
    localparam logic [4:0] S_FACC  = 5'd3;
    localparam logic [4:0] S_FWR   = 5'd4;
    localparam logic [4:0] S_MDRV  = 5'd5;
    localparam logic [4:0] S_ARG   = 5'd6;
    localparam logic [4:0] S_CINIT = 5'd7;
    localparam logic [4:0] S_CRD   = 5'd8;
    localparam logic [4:0] S_DRV   = 5'd9;
    localparam logic [4:0] S_MBL   = 5'd10;
    localparam logic [4:0] S_MCL   = 5'd11;
    localparam logic [4:0] S_MIX   = 5'd12;
    localparam logic [4:0] S_MLO   = 5'd13;
    localparam logic [4:0] S_MHI   = 5'd14;
    localparam logic [4:0] S_SUM   = 5'd15;
    localparam logic [4:0] S_OUT   = 5'd16;

    logic [4:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.mul_sel     = MUL_NONE;
        cmd.acc_op      = ACC_HOLD;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MB0;
                end
            end
            S_MB0:
            begin
                cmd.mul_sel = MUL_DIFF_B0;
                state_next  = S_MC;
            end
            S_MC:
            begin
                cmd.mul_sel = MUL_LF_C;
                cmd.acc_op  = ACC_LOAD_SH6;
                state_next  = S_FACC;
            end
            S_FACC:
            begin
                cmd.acc_op = ACC_ADD;
                state_next = S_FWR;
            end
            S_FWR:
            begin
                cmd.filt_wr = 1'b1;
                state_next  = S_MDRV;
            end
            S_MDRV:
            begin
                cmd.mul_sel = MUL_F_DRIVE;
                state_next  = S_ARG;
            end
            S_ARG:
            begin
                cmd.acc_op = ACC_LOAD;
                state_next = S_CINIT;
            end
            S_CINIT:
            begin
                cmd.cordic_init = 1'b1;
                state_next      = S_CRD;
            end
            S_CRD:
            begin
                cmd.cordic_step = 1'b1;
                if (status.cordic_last)
                begin
                    state_next = S_DRV;
                end
            end
            S_DRV:
            begin
                cmd.drv_wr = 1'b1;
                state_next = S_MBL;
            end
            S_MBL:
            begin
                cmd.mul_sel = MUL_DRV_BLEND;
                state_next  = S_MCL;
            end
            S_MCL:
            begin
                cmd.mul_sel = MUL_F_CLEAN;
                cmd.acc_op  = ACC_LOAD;
                state_next  = S_MIX;
            end
            S_MIX:
            begin
                cmd.acc_op = ACC_ADD_SH3;
                state_next = S_MLO;
            end
            S_MLO:
            begin
                cmd.mul_sel = MUL_LO_VOL;
                state_next  = S_MHI;
            end
            S_MHI:
            begin
                cmd.mul_sel = MUL_HI_VOL;
                cmd.acc_op  = ACC_LOAD;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                cmd.acc_op = ACC_ADD_SH24;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sim/highpass_atan_distortion_unit_tb.sv =====
// Self-checking testbench: predicts every output word of the distortion unit and compares.
`timescale 1ns / 1ps
module highpass_atan_distortion_unit_tb;
    import hpad_pkg::*;

    localparam int     CYCLE_LIMIT  = 1000000;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     TAIL_CYCLES  = 60;
    localparam int     CORDIC_STEPS = 10;
    localparam longint FILT_HI      = 64'sd8388607;
    localparam longint FILT_LO      = -64'sd8388608;
    localparam longint ARG_SAT      = 64'sd4096 <<< 29;
    localparam longint UNIT_ONE     = 64'sd1 <<< 29;
    localparam longint MIX_ONE      = 64'sd65536;
    localparam logic [CFG_DATA_W-1:0] DRIVE_TOP  = 20'd768000;
    localparam logic [CFG_DATA_W-1:0] VOLUME_TOP = 20'd49152;
    localparam cfg_idx_t CFG_SPARE_LO = CFG_VOLUME + 3'd1;
    localparam cfg_idx_t CFG_SPARE_HI = '1;

    typedef struct packed {
        logic                        ch;
        logic signed [SAMPLE_W-1:0]  smp;
    } audio_word_t;

    logic clk;
    logic rst_n;

    hpad_in_if  in_ch ();
    hpad_out_if out_ch ();
    hpad_cfg_if cfg ();

    highpass_atan_distortion_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    audio_word_t samples_pending[$];
    audio_word_t results_due[$];
    audio_word_t next_word;
    audio_word_t done_word;
    audio_word_t want;

    logic [COEF_W-1:0]  fwd_gain = HP_FORWARD_RST;
    logic [COEF_W-1:0]  fb_gain  = HP_FEEDBACK_RST;
    logic [DRIVE_W-1:0] drive    = DRIVE_RST;
    logic [BLEND_W-1:0] blend    = BLEND_RST;
    logic [VOL_W-1:0]   volume   = VOLUME_RST;
    longint prev_in   [NUM_CHANNELS_DEF];
    longint prev_filt [NUM_CHANNELS_DEF];

    int fail_count    = 0;
    int fed_count     = 0;
    int checked_count = 0;
    int cycle_count   = 0;

    int gap_left   = 0;
    int burst_left = 0;
    int gap_max    = 0;
    int burst_max  = 1;

    bit          sink_steady = 1'b1;
    logic [15:0] stall_pat   = '1;
    int          stall_pos   = 0;
    bit          hold_armed  = 1'b0;
    int          hold_left   = 0;

    function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint round_half_up(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // (2/pi)*atan(2^-i), units of 2^-24
    function automatic longint angle_step(input int i);
        case (i)
            0:       return 64'sd8388608;
            1:       return 64'sd4952084;
            2:       return 64'sd2616545;
            3:       return 64'sd1328199;
            4:       return 64'sd666677;
            5:       return 64'sd333663;
            6:       return 64'sd166872;
            7:       return 64'sd83441;
            8:       return 64'sd41721;
            9:       return 64'sd20861;
            default: return 64'sd0;
        endcase
    endfunction

    // t >= 0 in units of 2^-29, result (2/pi)*atan(t) in units of 2^-24
    function automatic longint atan_scaled(input longint t);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        int     i;
        if (t == 0)
            return 0;
        x = UNIT_ONE;
        y = t;
        z = 0;
        for (i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + angle_step(i);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - angle_step(i);
            end
        end
        return z;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] distort_sample(
        input logic ch, input logic signed [SAMPLE_W-1:0] smp);
        int     lane;
        longint x;
        longint acc;
        longint f;
        longint arg;
        longint drv;
        longint wet;
        longint mix;
        longint res;
        lane = int'(ch) % NUM_CHANNELS_DEF;
        x = longint'(smp);
        acc = (x - prev_in[lane]) * longint'(fwd_gain) * 64
            + prev_filt[lane] * longint'(fb_gain);
        f = clamp_range(round_half_up(acc, 16), FILT_LO, FILT_HI);
        prev_in[lane] = x;
        prev_filt[lane] = f;
        arg = clamp_range(f * longint'(drive), -ARG_SAT, ARG_SAT);
        drv = atan_scaled((arg < 0) ? -arg : arg);
        if (arg < 0)
            drv = -drv;
        wet = longint'(blend);
        if (wet > MIX_ONE)
            wet = MIX_ONE;
        mix = drv * wet + f * (MIX_ONE - wet) * 8;
        res = clamp_range(round_half_up(mix * longint'(volume), 40), -64'sd32768, 64'sd32767);
        return res[SAMPLE_W-1:0];
    endfunction

    task automatic push_word(input int ch, input int smp);
        audio_word_t w;
        w.ch = 1'(ch);
        w.smp = 16'(smp);
        samples_pending = {samples_pending, w};
        fed_count++;
    endtask

    task automatic wait_drained();
        while (checked_count != fed_count)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            CFG_HP_FORWARD:  fwd_gain = value[COEF_W-1:0];
            CFG_HP_FEEDBACK: fb_gain  = value[COEF_W-1:0];
            CFG_DRIVE:       drive    = value[DRIVE_W-1:0];
            CFG_BLEND:       blend    = value[BLEND_W-1:0];
            CFG_VOLUME:      volume   = value[VOL_W-1:0];
            default:         ;
        endcase
    endtask

    // junk above the register width now and then; the block must mask it
    function automatic logic [CFG_DATA_W-1:0] with_spill(input logic [CFG_DATA_W-1:0] v,
                                                         input int width);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        if ($urandom_range(0, 3) == 0)
            v = v | ((junk >> width) << width);
        return v;
    endfunction

    task automatic pick_settings();
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 3))
            0:       v = '0;
            1:       v = 20'hFFFF;
            2:       v = 20'($urandom_range(50000, 65535));
            default: v = 20'($urandom_range(0, 65535));
        endcase
        write_reg(CFG_HP_FORWARD, with_spill(v, COEF_W));
        case ($urandom_range(0, 3))
            0:       v = '0;
            1:       v = 20'hFFFF;
            2:       v = 20'($urandom_range(0, 65535));
            default: v = 20'($urandom_range(55000, 65535));
        endcase
        write_reg(CFG_HP_FEEDBACK, with_spill(v, COEF_W));
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = DRIVE_TOP;
            2:       v = 20'hFFFFF;
            3:       v = 20'($urandom_range(0, 2048));
            default: v = 20'($urandom_range(0, DRIVE_TOP));
        endcase
        write_reg(CFG_DRIVE, v);
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = 20'd65536;
            2:       v = 20'h1FFFF;
            3:       v = 20'($urandom_range(65537, 131071));
            default: v = 20'($urandom_range(0, 65536));
        endcase
        write_reg(CFG_BLEND, with_spill(v, BLEND_W));
        case ($urandom_range(0, 4))
            0:       v = '0;
            1:       v = VOLUME_TOP;
            2:       v = 20'hFFFF;
            default: v = 20'($urandom_range(0, VOLUME_TOP));
        endcase
        write_reg(CFG_VOLUME, with_spill(v, VOL_W));
        if ($urandom_range(0, 1) == 0)
            write_reg(cfg_idx_t'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 20'($urandom));
    endtask

    // mostly interleaved stereo; random walks, full-range noise, small noise and extremes
    task automatic queue_samples(input int count);
        int walk [NUM_CHANNELS_DEF];
        int ch;
        int smp;
        int step_max;
        int n;
        walk[0] = 0;
        walk[1] = 0;
        ch = 0;
        step_max = $urandom_range(16, 8192);
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 3) == 0)
                ch = $urandom_range(0, 1);
            else
                ch = 1 - ch;
            case ($urandom_range(0, 7))
                0, 1, 2, 3:
                begin
                    smp = walk[ch] + $urandom_range(0, 2 * step_max) - step_max;
                    smp = (smp > 32767) ? 32767 : ((smp < -32768) ? -32768 : smp);
                    walk[ch] = smp;
                end
                4, 5:    smp = $urandom_range(0, 65535) - 32768;
                6:       smp = $urandom_range(0, 255) - 128;
                default:
                begin
                    case ($urandom_range(0, 4))
                        0:       smp = 32767;
                        1:       smp = -32768;
                        2:       smp = 0;
                        3:       smp = 1;
                        default: smp = -1;
                    endcase
                end
            endcase
            push_word(ch, smp);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // sample driver: bursts of random length with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid      <= 1'b0;
            in_ch.channel_id <= 1'b0;
            in_ch.sample_in  <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                done_word.ch = in_ch.channel_id;
                done_word.smp = distort_sample(in_ch.channel_id, in_ch.sample_in);
                results_due = {results_due, done_word};
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end
                else if (samples_pending.size() != 0)
                begin
                    next_word = samples_pending.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.channel_id <= next_word.ch;
                    in_ch.sample_in  <= next_word.smp;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, burst_max);
                        gap_left = $urandom_range(0, gap_max);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected word: channel_out %0d, sample_out %0d",
                           out_ch.channel_out, out_ch.sample_out);
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    checked_count++;
                    if (out_ch.channel_out !== want.ch)
                    begin
                        $error("channel_out mismatch: expected %0d, got %0d",
                               want.ch, out_ch.channel_out);
                        fail_count++;
                    end
                    if (out_ch.sample_out !== want.smp)
                    begin
                        $error("sample_out mismatch: expected %0d, got %0d",
                               want.smp, out_ch.sample_out);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (hold_armed && out_ch.valid)
            begin
                hold_armed = 1'b0;
                hold_left = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end
            else if (sink_steady)
            begin
                out_ch.ready <= 1'b1;
            end
            else
            begin
                out_ch.ready <= stall_pat[stall_pos];
                stall_pos = (stall_pos + 1) % 16;
                if (stall_pos == 0 && $urandom_range(0, 3) == 0)
                    stall_pat = 16'($urandom);
            end
        end
    end

    initial
    begin
        int phase;
        cfg.valid        = 1'b0;
        cfg.index        = CFG_HP_FORWARD;
        cfg.data         = '0;
        prev_in[0]   = 0;
        prev_in[1]   = 0;
        prev_filt[0] = 0;
        prev_filt[1] = 0;
        rst_n = 1'b0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: zero input, full-scale steps, unit steps
        push_word(0, 0);
        push_word(1, 0);
        push_word(0, 32767);
        push_word(1, -32768);
        push_word(0, -32768);
        push_word(1, 32767);
        push_word(0, 1);
        push_word(1, -1);
        push_word(0, 0);
        push_word(1, 0);
        wait_drained();

        // all gains at top, with bits above width where the register is narrower, blend over one, spare indexes
        write_reg(CFG_HP_FORWARD, 20'hFFFFF);
        write_reg(CFG_HP_FEEDBACK, 20'h3FFFF);
        write_reg(CFG_DRIVE, 20'hFFFFF);
        write_reg(CFG_BLEND, 20'hFFFFF);
        write_reg(CFG_VOLUME, 20'hFFFFF);
        write_reg(CFG_SPARE_LO, 20'h00000);
        write_reg(CFG_SPARE_HI, 20'hFFFFF);
        push_word(0, 32767);
        push_word(0, -32768);
        push_word(1, -32768);
        push_word(1, 32767);
        push_word(0, 32767);
        push_word(1, 0);
        push_word(0, 0);
        push_word(0, -32768);
        wait_drained();

        // all zero: no filter, no drive, clean path only, muted
        write_reg(CFG_HP_FORWARD, 20'd0);
        write_reg(CFG_HP_FEEDBACK, 20'd0);
        write_reg(CFG_DRIVE, 20'd0);
        write_reg(CFG_BLEND, 20'd0);
        write_reg(CFG_VOLUME, 20'd0);
        push_word(0, 12345);
        push_word(1, -23456);
        push_word(0, -32768);
        push_word(1, 32767);
        wait_drained();

        for (phase = 0; phase < 8; phase++)
        begin
            pick_settings();
            case ($urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 4;
                default: gap_max = 40;
            endcase
            case ($urandom_range(0, 2))
                0:       burst_max = 1;
                1:       burst_max = 4;
                default: burst_max = 16;
            endcase
            sink_steady = ($urandom_range(0, 2) == 0);
            if (phase == 2)
            begin
                gap_max = 0;
                hold_armed = 1'b1;
            end
            queue_samples(80);
            wait_drained();
        end

        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && results_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== highpass_atan_distortion_unit.f =====
hw/rtl/hpad_pkg.sv
hw/rtl/hpad_ifs.sv
hw/rtl/hpad_cordic.sv
hw/rtl/hpad_datapath.sv
hw/rtl/hpad_ctrl.sv
hw/rtl/highpass_atan_distortion_unit.sv
sim/highpass_atan_distortion_unit_tb.sv
